/* design/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared widths, codes and index helpers for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int DEPTH      = 256;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int FUNC_W     = 3;

  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ITEM_WIDTH-1:0] item_t;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    item_t wr_data;
    idx_t  rd_addr;
  } store_req_t;

  function automatic idx_t idx_up(input idx_t idx);
    return (idx == idx_t'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic idx_t idx_down(input idx_t idx);
    return (idx == '0) ? idx_t'(DEPTH - 1) : idx - 1'b1;
  endfunction

endpackage

/* design/rbd_store.sv */
// ----------------------------------------------------------------------------
// rbd_store
// Slot storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbd_store (
  input  logic                clk,
  input  rbd_pkg::store_req_t req,
  output rbd_pkg::item_t      rd_data
);

  rbd_pkg::item_t mem [rbd_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

/* design/ring_buffer_deque.sv */
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Fixed-capacity double-ended queue in a circular slot store.
// ----------------------------------------------------------------------------
// One request is taken in every cycle: busy stays low, so start may be held
// high continuously. Each request yields one result, marked by done, once it
// has passed the stage one registers and then the result registers; results
// come in request order and must be taken when shown. The front and back
// items are kept in registers, so a request needs at most one store read (the
// new front after a pop front or the new back after a pop back); that read is
// the registered port of the slot store. A back-to-back request sees the
// previous request's front and back through a bypass, so no bubbles arise.
module ring_buffer_deque (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [rbd_pkg::FUNC_W-1:0]     func,
  input  logic [rbd_pkg::ITEM_WIDTH-1:0] push_value,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [rbd_pkg::ITEM_WIDTH-1:0] popped_value,
  output logic [rbd_pkg::CNT_W-1:0]      entry_count,
  output logic [rbd_pkg::ITEM_WIDTH-1:0] front_value,
  output logic [rbd_pkg::ITEM_WIDTH-1:0] back_value
);

  rbd_pkg::idx_t head;
  rbd_pkg::idx_t tail;
  rbd_pkg::cnt_t held;

  logic             s1_valid;
  rbd_pkg::status_t s1_status;
  rbd_pkg::item_t   s1_popped;
  rbd_pkg::cnt_t    s1_count;
  rbd_pkg::item_t   s1_front;
  rbd_pkg::item_t   s1_back;
  logic             s1_front_mem;
  logic             s1_back_mem;

  rbd_pkg::store_req_t req;
  rbd_pkg::item_t      rd_data;

  rbd_pkg::item_t   front_next;
  rbd_pkg::item_t   back_next;
  rbd_pkg::item_t   cur_front;
  rbd_pkg::item_t   cur_back;

  rbd_pkg::idx_t    head_next;
  rbd_pkg::idx_t    tail_next;
  rbd_pkg::cnt_t    held_next;
  rbd_pkg::status_t st_next;
  rbd_pkg::item_t   popped_next;
  rbd_pkg::item_t   nf;
  rbd_pkg::item_t   nb;
  logic             fm;
  logic             bm;
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start;

  rbd_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // finish the beat in stage one, and bypass it to the next beat
  assign front_next = s1_front_mem ? rd_data : s1_front;
  assign back_next  = s1_back_mem  ? rd_data : s1_back;
  assign cur_front  = s1_valid ? front_next : front_value;
  assign cur_back   = s1_valid ? back_next  : back_value;

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    held_next   = held;
    st_next     = rbd_pkg::ST_OK;
    popped_next = '0;
    nf          = cur_front;
    nb          = cur_back;
    fm          = 1'b0;
    bm          = 1'b0;
    req.wr_en   = 1'b0;
    req.wr_addr = tail;
    req.wr_data = push_value;
    req.rd_addr = rbd_pkg::idx_up(head);
    unique case (func)
      rbd_pkg::FUNC_PUSH_FRONT: begin
        if (held == rbd_pkg::cnt_t'(rbd_pkg::DEPTH)) begin
          st_next = rbd_pkg::ST_FULL;
        end else begin
          head_next   = rbd_pkg::idx_down(head);
          held_next   = held + 1'b1;
          req.wr_en   = accept;
          req.wr_addr = head_next;
          nf          = push_value;
          if (held == '0) begin
            nb = push_value;
          end
        end
      end
      rbd_pkg::FUNC_PUSH_BACK: begin
        if (held == rbd_pkg::cnt_t'(rbd_pkg::DEPTH)) begin
          st_next = rbd_pkg::ST_FULL;
        end else begin
          tail_next   = rbd_pkg::idx_up(tail);
          held_next   = held + 1'b1;
          req.wr_en   = accept;
          req.wr_addr = tail;
          nb          = push_value;
          if (held == '0) begin
            nf = push_value;
          end
        end
      end
      rbd_pkg::FUNC_POP_FRONT: begin
        if (held == '0) begin
          st_next = rbd_pkg::ST_EMPTY;
        end else begin
          popped_next = cur_front;
          head_next   = rbd_pkg::idx_up(head);
          held_next   = held - 1'b1;
          req.rd_addr = rbd_pkg::idx_up(head);
          if (held == rbd_pkg::cnt_t'(1)) begin
            nf = '0;
            nb = '0;
          end else if (held == rbd_pkg::cnt_t'(2)) begin
            nf = cur_back;
          end else begin
            fm = 1'b1;
          end
        end
      end
      rbd_pkg::FUNC_POP_BACK: begin
        if (held == '0) begin
          st_next = rbd_pkg::ST_EMPTY;
        end else begin
          popped_next = cur_back;
          tail_next   = rbd_pkg::idx_down(tail);
          held_next   = held - 1'b1;
          req.rd_addr = rbd_pkg::idx_down(rbd_pkg::idx_down(tail));
          if (held == rbd_pkg::cnt_t'(1)) begin
            nf = '0;
            nb = '0;
          end else if (held == rbd_pkg::cnt_t'(2)) begin
            nb = cur_front;
          end else begin
            bm = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      held        <= '0;
      s1_valid    <= 1'b0;
      done        <= 1'b0;
      front_value <= '0;
      back_value  <= '0;
    end else begin
      s1_valid <= accept;
      done     <= s1_valid;
      if (accept) begin
        head <= head_next;
        tail <= tail_next;
        held <= held_next;
      end
      if (s1_valid) begin
        front_value <= front_next;
        back_value  <= back_next;
      end
    end
  end

  // payload: hold stage one and result fields without reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status    <= st_next;
      s1_popped    <= popped_next;
      s1_count     <= held_next;
      s1_front     <= nf;
      s1_back      <= nb;
      s1_front_mem <= fm;
      s1_back_mem  <= bm;
    end
    if (s1_valid) begin
      status       <= s1_status;
      popped_value <= s1_popped;
      entry_count  <= s1_count;
    end
  end

endmodule
